// File: design/brp_pkg.sv
// Shared constants and types for the base-2048 bit repacker.
// Used by the interfaces, the step logic, the result queue and the top level.
`timescale 1ns / 1ps

package brp_pkg;

   // Field widths.
   localparam int SYM_BITS  = 11;
   localparam int BYTE_BITS = 8;
   localparam int ACC_W     = 18;
   localparam int HELD_W    = 5;

   // Direction register codes.
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // One result word.
   typedef struct packed {
      logic [SYM_BITS-1:0] data;
      logic                last;
   } result_type;

   // Results produced by one input word, in output order.
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

// File: design/brp_if.sv
// Channel interfaces for the bit repacker: request, response and register write.
// Depends on brp_pkg for field widths.
`timescale 1ns / 1ps

interface brp_req_if;
   import brp_pkg::*;
   logic                valid;
   logic                ready;
   logic [SYM_BITS-1:0] data_in;
   logic                in_last;
   modport source (output valid, output data_in, output in_last, input ready);
   modport sink (input valid, input data_in, input in_last, output ready);
endinterface

interface brp_rsp_if;
   import brp_pkg::*;
   logic                valid;
   logic                ready;
   logic [SYM_BITS-1:0] data_out;
   logic                out_last;
   modport source (output valid, output data_out, output out_last, input ready);
   modport sink (input valid, input data_out, input out_last, output ready);
endinterface

interface brp_csr_if;
   logic valid;
   logic ready;
   logic direction;
   modport source (output valid, output direction, input ready);
   modport sink (input valid, input direction, output ready);
endinterface

// File: design/brp_step.sv
// Combinational step of the repacker: merges one input word into the bit
// accumulator and forms up to two result words. Depends on brp_pkg.
`timescale 1ns / 1ps

module brp_step
   import brp_pkg::*;
(
   input  logic                direction,
   input  logic [ACC_W-1:0]    acc,
   input  logic [HELD_W-1:0]   held,
   input  logic [SYM_BITS-1:0] data_in,
   input  logic                in_last,
   output logic [ACC_W-1:0]    acc_next,
   output logic [HELD_W-1:0]   held_next,
   output push_type            push
);

   logic [ACC_W-1:0]    merged;
   logic [HELD_W-1:0]   held_sum;
   logic [ACC_W-1:0]    acc_left;
   logic [HELD_W-1:0]   held_left;
   logic [1:0]          n;
   logic [SYM_BITS-1:0] d0;
   logic [SYM_BITS-1:0] d1;

   always_comb begin
      merged    = '0;
      held_sum  = '0;
      acc_left  = '0;
      held_left = '0;
      n         = 2'd0;
      d0        = '0;
      d1        = '0;
      unique case (direction)
         DIR_ENCODE: begin
            // Append the byte above the held bits; emit a symbol once 11 are held.
            merged   = acc | (ACC_W'(data_in[BYTE_BITS-1:0]) << held);
            held_sum = held + HELD_W'(BYTE_BITS);
            if (held_sum >= HELD_W'(SYM_BITS)) begin
               d0        = merged[SYM_BITS-1:0];
               acc_left  = merged >> SYM_BITS;
               held_left = held_sum - HELD_W'(SYM_BITS);
               n         = 2'd1;
            end else begin
               acc_left  = merged;
               held_left = held_sum;
            end
            // On the last byte, flush leftover bits as a zero-padded symbol.
            if (in_last && (held_left != '0)) begin
               if (n == 2'd0) begin
                  d0 = acc_left[SYM_BITS-1:0];
               end else begin
                  d1 = acc_left[SYM_BITS-1:0];
               end
               n = n + 2'd1;
            end
         end
         DIR_DECODE: begin
            // Append the symbol; one or two whole bytes come out.
            merged   = acc | (ACC_W'(data_in) << held);
            held_sum = held + HELD_W'(SYM_BITS);
            d0       = SYM_BITS'(merged[BYTE_BITS-1:0]);
            if (held_sum >= HELD_W'(2 * BYTE_BITS)) begin
               d1        = SYM_BITS'(merged[2*BYTE_BITS-1:BYTE_BITS]);
               acc_left  = merged >> (2 * BYTE_BITS);
               held_left = held_sum - HELD_W'(2 * BYTE_BITS);
               n         = 2'd2;
            end else begin
               acc_left  = merged >> BYTE_BITS;
               held_left = held_sum - HELD_W'(BYTE_BITS);
               n         = 2'd1;
            end
         end
         default: begin
            n = 2'd0;
         end
      endcase
   end

   // The message end clears the state and tags the final result.
   assign acc_next       = in_last ? '0 : acc_left;
   assign held_next      = in_last ? '0 : held_left;
   assign push.count     = n;
   assign push.res0.data = d0;
   assign push.res0.last = in_last && (n == 2'd1);
   assign push.res1.data = d1;
   assign push.res1.last = in_last && (n == 2'd2);

endmodule

// File: design/brp_queue.sv
// Four-entry result queue: takes up to two words per cycle, gives one.
// Depends on brp_pkg.
`timescale 1ns / 1ps

module brp_queue
   import brp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space,
   output logic       head_valid,
   output result_type head,
   input  logic       pop_ready
);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   pop;

   // Room for the worst case of two words from the next input.
   assign space      = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign pop        = head_valid && pop_ready;

   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
   assign count_in  = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; the second word goes one slot after the first.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + QUEUE_PTR_W'(1)] <= push.res1;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue count exceeds its depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2)))
      else $error("result pushed without room for two words");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == QUEUE_PTR_W'(count_ff))
      else $error("queue pointers disagree with fill count");
`endif

endmodule

// File: design/base2048_bit_repacker_unit.sv
// Top level of the base-2048 bit repacker: state registers, register port,
// step logic and result queue. Depends on brp_pkg, brp_if, brp_step, brp_queue.
//
// Channel     Dir  Payload                 Role
// req_word    in   data_in[10:0], in_last  bytes (pack) or symbols (unpack)
// rsp_word    out  data_out[10:0], out_last symbols (pack) or bytes (unpack)
// csr_write   in   direction               0 packs, 1 unpacks; clears state
//
// A request word yields zero, one or two response words, which enter a
// four-entry queue at the edge that accepts it; the first can leave on the
// next cycle. The queue takes a request while it has room for two words,
// so with the response side ready it takes one request per cycle when each
// makes at most one word; when each makes two, the single response port
// sets the rate. Synchronous reset clears direction, accumulator
// and queue. A stalled response side fills the queue and then drops req ready.
`timescale 1ns / 1ps

module base2048_bit_repacker_unit
   import brp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   brp_req_if.sink   req_word,
   brp_rsp_if.source rsp_word,
   brp_csr_if.sink   csr_write
);

   logic              dir_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;
   logic [HELD_W-1:0] held_ff;
   logic [HELD_W-1:0] held_in;
   logic              req_fire;
   logic              space;
   push_type          step_push;
   push_type          push;
   result_type        head;
   logic              head_valid;

   assign csr_write.ready = 1'b1;
   assign req_word.ready  = space;
   assign req_fire        = req_word.valid && space;

   // Merge the incoming word into the accumulator.
   brp_step u_step (
      .direction (dir_ff),
      .acc       (acc_ff),
      .held      (held_ff),
      .data_in   (req_word.data_in),
      .in_last   (req_word.in_last),
      .acc_next  (acc_in),
      .held_next (held_in),
      .push      (step_push)
   );

   // Only an accepted word pushes results.
   always_comb begin
      push = step_push;
      if (!req_fire) begin
         push.count = 2'd0;
      end
   end

   // Direction register and accumulator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= DIR_ENCODE;
         acc_ff  <= '0;
         held_ff <= '0;
      end else if (csr_write.valid) begin
         dir_ff  <= csr_write.direction;
         acc_ff  <= '0;
         held_ff <= '0;
      end else if (req_fire) begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
      end
   end

   // Response words leave through the queue.
   brp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space      (space),
      .head_valid (head_valid),
      .head       (head),
      .pop_ready  (rsp_word.ready)
   );

   assign rsp_word.valid    = head_valid;
   assign rsp_word.data_out = head.data;
   assign rsp_word.out_last = head.last;

`ifndef ASSERT_OFF
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      (dir_ff == DIR_ENCODE) ? (held_ff <= HELD_W'(SYM_BITS - 1))
                             : (held_ff <= HELD_W'(BYTE_BITS - 1)))
      else $error("held bit count out of range for the direction");

   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      (acc_ff >> held_ff) == '0)
      else $error("accumulator holds bits above the held count");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_word.in_last && !csr_write.valid) |=> (held_ff == '0))
      else $error("state not cleared after the last word");
`endif

endmodule

// File: dv/testbench.sv
// Self-checking testbench for base2048_bit_repacker_unit: packs bytes into 11-bit symbols and
// unpacks symbols into bytes, predicting every response word in a scoreboard class.
// Depends on brp_pkg, the channel interfaces in brp_if and the repacker RTL.
`timescale 1ns / 1ps

module testbench;
   import brp_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int TAIL_CYCLES  = 20;
   localparam int PHASES       = 12;
   localparam int PHASE_WORDS  = 100;
   localparam int MAX_REPORTS  = 100;

   logic clock;
   logic reset;

   // Idle percentage shared by both sides, and a request for one long response stall.
   int idle_pct = 20;
   bit hold_request = 1'b0;

   brp_req_if req_bus ();
   brp_rsp_if rsp_bus ();
   brp_csr_if csr_bus ();

   base2048_bit_repacker_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_bus),
      .rsp_word  (rsp_bus),
      .csr_write (csr_bus)
   );

   // Gearbox predictor: keeps its own accumulator and bit count and queues
   // the response words that each accepted request word should produce.
   class repack_scoreboard;
      logic             direction;
      logic [ACC_W-1:0] acc;
      logic [HELD_W-1:0] held;
      result_type       pending_q[$];
      int               errors;

      function new();
         direction = DIR_ENCODE;
         acc = '0;
         held = '0;
         errors = 0;
      endfunction

      // A direction write abandons any partial message.
      function void set_direction(logic dir);
         direction = dir;
         acc = '0;
         held = '0;
      endfunction

      function void note_word(logic [SYM_BITS-1:0] word, logic last);
         logic [ACC_W-1:0] incoming;
         result_type       made[$];
         result_type       res;
         incoming = '0;
         if (direction == DIR_ENCODE) begin
            // Only the low byte counts; bits 10..8 are ignored.
            incoming[BYTE_BITS-1:0] = word[BYTE_BITS-1:0];
            acc = acc | (incoming << held);
            held = held + HELD_W'(BYTE_BITS);
            if (held >= SYM_BITS) begin
               res.data = acc[SYM_BITS-1:0];
               res.last = 1'b0;
               made.push_back(res);
               acc = acc >> SYM_BITS;
               held = held - HELD_W'(SYM_BITS);
            end
            // Flush the remaining bits as a zero-padded symbol.
            if (last && held != 0) begin
               res.data = acc[SYM_BITS-1:0];
               res.last = 1'b0;
               made.push_back(res);
            end
         end else begin
            incoming[SYM_BITS-1:0] = word;
            acc = acc | (incoming << held);
            held = held + HELD_W'(SYM_BITS);
            while (held >= BYTE_BITS && made.size() < 2) begin
               res.data = '0;
               res.data[BYTE_BITS-1:0] = acc[BYTE_BITS-1:0];
               res.last = 1'b0;
               made.push_back(res);
               acc = acc >> BYTE_BITS;
               held = held - HELD_W'(BYTE_BITS);
            end
         end
         // The final word of a message carries the last flag; leftovers are dropped.
         if (last) begin
            if (made.size() > 0) made[made.size()-1].last = 1'b1;
            acc = '0;
            held = '0;
         end
         foreach (made[i]) pending_q.push_back(made[i]);
      endfunction

      function void check_word(logic [SYM_BITS-1:0] data, logic last);
         result_type want;
         if (pending_q.size() == 0) begin
            if (errors < MAX_REPORTS)
               $error("data_out: expected no word, actual %0h (out_last %0b)", data, last);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (data !== want.data) begin
            if (errors < MAX_REPORTS)
               $error("data_out: expected %0h, actual %0h", want.data, data);
            errors++;
         end
         if (last !== want.last) begin
            if (errors < MAX_REPORTS)
               $error("out_last: expected %0b, actual %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   repack_scoreboard sb = new();

   // Free-running clock, 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Mostly no gap, some short ones and a few long ones, scaled by idle_pct.
   function automatic int pick_gap();
      if (idle_pct == 0 || $urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Sample every handshake at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) sb.set_direction(csr_bus.direction);
         if (req_bus.valid && req_bus.ready) sb.note_word(req_bus.data_in, req_bus.in_last);
         if (rsp_bus.valid && rsp_bus.ready) sb.check_word(rsp_bus.data_out, rsp_bus.out_last);
      end
   end

   // Response side: random stalls, plus one long hold when requested.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               rsp_bus.ready = 1'b0;
               stall_left--;
            end else begin
               rsp_bus.ready = 1'b1;
            end
         end
      end
   end

   // Offer one request word after a random gap and wait for it to be taken.
   // Valid stays high on return so back-to-back words need no extra step.
   task automatic send_word(input logic [SYM_BITS-1:0] word, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.data_in = word;
      req_bus.in_last = last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and wait for every predicted word to come back.
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
   endtask

   // Direction writes happen only with the block idle. Byte words that make no
   // symbol leave nothing to wait for, so allow a few more cycles first.
   task automatic write_direction(input logic dir);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.direction = dir;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Time limit for the whole run.
   initial begin
      #20_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // Main sequence: reset, directed messages, then random phases.
   initial begin
      int  len;
      int  sent;
      bit  terminate;
      logic dir;
      req_bus.valid = 1'b0;
      req_bus.data_in = '0;
      req_bus.in_last = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.direction = DIR_ENCODE;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Packing after reset: a single byte flushed alone.
      send_word(11'h0FF, 1'b1);
      // Upper bits of the byte word are ignored; ends with a padded flush.
      send_word(11'h7FF, 1'b0);
      send_word(11'h000, 1'b0);
      send_word(11'h5A5, 1'b1);
      // Eleven bytes fill exactly eight symbols, so nothing is left to flush.
      for (int k = 0; k < 11; k++)
         send_word(11'h7FF ^ 11'(k * 29), k == 10);
      // A partial message abandoned by the direction write.
      send_word(11'h0AA, 1'b0);
      write_direction(DIR_DECODE);

      // Unpacking: leftover bits dropped at the end of a message.
      send_word(11'h7FF, 1'b1);
      // Third symbol completes two bytes; the second carries the last flag.
      send_word(11'h000, 1'b0);
      send_word(11'h7FF, 1'b0);
      send_word(11'h555, 1'b1);
      // Partial message left for the next direction write to clear.
      send_word(11'h400, 1'b0);

      // Random messages, each phase with its own direction and idle level.
      for (int phase = 0; phase < PHASES; phase++) begin
         dir = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
         write_direction(dir);
         idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 15 : 50);
         // Long response stall while requests keep coming.
         if (phase == 3) hold_request = 1'b1;
         sent = 0;
         while (sent < PHASE_WORDS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            // The closing message of a phase is sometimes left open.
            terminate = (sent + len < PHASE_WORDS) || $urandom_range(0, 1);
            for (int k = 0; k < len; k++)
               send_word(11'($urandom_range(0, 2047)), terminate && k == len - 1);
            sent += len;
            if ($urandom_range(0, 29) == 0 || (phase == 5 && sent < 20)) wait_drained();
         end
      end

      idle_pct = 0;
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
